// ----- rtl/msfd_pkg.sv -----
package msfd_pkg;

  localparam int unsigned LEN_W = 25;

  localparam logic [31:0] SYNC_MAGIC   = 32'h5343_4E31;
  localparam logic [15:0] SYNC_VERSION = 16'h0001;
  localparam logic [47:0] SYNC_PATTERN = {SYNC_MAGIC, SYNC_VERSION};
  localparam logic [2:0]  SYNC_FILL    = 3'd6;

  localparam logic [3:0] HDR_START     = 4'd6;
  localparam logic [3:0] HDR_TYPE_LAST = 4'd7;
  localparam logic [3:0] HDR_LEN_FIRST = 4'd8;
  localparam logic [3:0] HDR_LEN_LAST  = 4'd11;
  localparam logic [3:0] HDR_LAST      = 4'd15;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(1024 * 1024);
  localparam logic [15:0]      TYPE_RESET        = 16'd1;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_MAX_PAYLOAD   = 1'b0;
  localparam logic REG_ACCEPTED_TYPE = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_payload_bytes;
    logic [15:0]      accepted_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_byte;
    logic       last_byte;
  } result_t;

endpackage

// ----- rtl/msfd_regs.sv -----
module msfd_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [msfd_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready,
  output msfd_pkg::cfg_t               cfg
);

  logic [msfd_pkg::LEN_W-1:0] max_len_r;
  logic [15:0]                acc_type_r;
  logic                       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= msfd_pkg::MAX_PAYLOAD_RESET;
      acc_type_r <= msfd_pkg::TYPE_RESET;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        msfd_pkg::REG_MAX_PAYLOAD:   max_len_r  <= cfg_pwdata[msfd_pkg::LEN_W-1:0];
        msfd_pkg::REG_ACCEPTED_TYPE: acc_type_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      msfd_pkg::REG_MAX_PAYLOAD:   cfg_prdata = 32'(max_len_r);
      msfd_pkg::REG_ACCEPTED_TYPE: cfg_prdata = 32'(acc_type_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  assign cfg.max_payload_bytes = max_len_r;
  assign cfg.accepted_type     = acc_type_r;

endmodule

// ----- rtl/msfd_core.sv -----
module msfd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  msfd_pkg::cfg_t      cfg,
  output logic                res_valid,
  output msfd_pkg::result_t   res
);

  logic [47:0]                window_r, window_nxt;
  logic [2:0]                 fill_r, fill_nxt;
  msfd_pkg::phase_t           phase_r, phase_nxt;
  logic [3:0]                 hdr_cnt_r, hdr_cnt_nxt;
  logic [15:0]                type_r, type_nxt;
  logic [31:0]                len_r, len_nxt;
  logic [msfd_pkg::LEN_W-1:0] left_r, left_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= '0;
      fill_r    <= '0;
      phase_r   <= msfd_pkg::PH_HUNT;
      hdr_cnt_r <= '0;
      type_r    <= '0;
      len_r     <= '0;
      left_r    <= '0;
    end else if (accept) begin
      window_r  <= window_nxt;
      fill_r    <= fill_nxt;
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      type_r    <= type_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
    end
  end

  always_comb begin
    window_nxt       = window_r;
    fill_nxt         = fill_r;
    phase_nxt        = phase_r;
    hdr_cnt_nxt      = hdr_cnt_r;
    type_nxt         = type_r;
    len_nxt          = len_r;
    left_nxt         = left_r;
    res_valid        = 1'b0;
    res.payload_byte = data_byte;
    res.first_byte   = (left_r == len_r[msfd_pkg::LEN_W-1:0]);
    res.last_byte    = (left_r == msfd_pkg::LEN_W'(1));

    unique case (phase_r)
      msfd_pkg::PH_HEAD: begin
        if (hdr_cnt_r == msfd_pkg::HDR_START || hdr_cnt_r == msfd_pkg::HDR_TYPE_LAST) begin
          type_nxt = {type_r[7:0], data_byte};
        end else if (hdr_cnt_r >= msfd_pkg::HDR_LEN_FIRST &&
                     hdr_cnt_r <= msfd_pkg::HDR_LEN_LAST) begin
          len_nxt = {len_r[23:0], data_byte};
        end
        hdr_cnt_nxt = hdr_cnt_r + 4'd1;
        if (hdr_cnt_r == msfd_pkg::HDR_LAST) begin
          // drop oversized or empty frames and hunt again
          if (len_r > 32'(cfg.max_payload_bytes) || len_r == '0) begin
            window_nxt  = '0;
            fill_nxt    = '0;
            hdr_cnt_nxt = '0;
            phase_nxt   = msfd_pkg::PH_HUNT;
          end else begin
            left_nxt  = len_r[msfd_pkg::LEN_W-1:0];
            phase_nxt = msfd_pkg::PH_BODY;
          end
        end
      end

      msfd_pkg::PH_BODY: begin
        res_valid = (type_r == cfg.accepted_type);
        if (left_r <= msfd_pkg::LEN_W'(1)) begin
          left_nxt    = '0;
          window_nxt  = '0;
          fill_nxt    = '0;
          hdr_cnt_nxt = '0;
          phase_nxt   = msfd_pkg::PH_HUNT;
        end else begin
          left_nxt = left_r - msfd_pkg::LEN_W'(1);
        end
      end

      default: begin
        // hunting; the unused phase code lands here too
        phase_nxt  = msfd_pkg::PH_HUNT;
        window_nxt = {window_r[39:0], data_byte};
        fill_nxt   = (fill_r < msfd_pkg::SYNC_FILL) ? fill_r + 3'd1 : fill_r;
        if (fill_nxt >= msfd_pkg::SYNC_FILL && window_nxt == msfd_pkg::SYNC_PATTERN) begin
          phase_nxt   = msfd_pkg::PH_HEAD;
          hdr_cnt_nxt = msfd_pkg::HDR_START;
          type_nxt    = '0;
          len_nxt     = '0;
        end
      end
    endcase
  end

endmodule

// ----- rtl/msfd_outbuf.sv -----
module msfd_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  msfd_pkg::result_t push_res,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output msfd_pkg::result_t out_res
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  msfd_pkg::result_t out_res_r, out_res_nxt;
  msfd_pkg::result_t skid_res_r, skid_res_nxt;
  logic              pop;

  assign pop       = out_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      // advance the waiting word
      if (pop) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_res_nxt   = push_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

endmodule

// ----- rtl/magic_sync_frame_deframer.sv -----
// A payload word is registered in the output register, or in the skid stage while that register holds a stalled word.
// Throughput: one byte per cycle while in_ready is high; the header decode is a single step per byte.
// in_ready drops only while two results wait, held by the output register and skid stage.
// Reset: synchronous, active low; clears the hunt state and output stage and
// restores max_payload_bytes to 1048576 and accepted_type to 1.
module magic_sync_frame_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_payload_byte,
  output logic                        out_first_byte,
  output logic                        out_last_byte,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [msfd_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  msfd_pkg::cfg_t    cfg;
  msfd_pkg::result_t core_res;
  msfd_pkg::result_t buf_res;
  logic              core_valid;
  logic              accept;

  assign accept = in_valid && in_ready;

  msfd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  msfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .cfg       (cfg),
    .res_valid (core_valid),
    .res       (core_res)
  );

  msfd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && core_valid),
    .push_res  (core_res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (buf_res)
  );

  assign out_payload_byte = buf_res.payload_byte;
  assign out_first_byte   = buf_res.first_byte;
  assign out_last_byte    = buf_res.last_byte;

endmodule

// ----- rtl/msfd_checker.sv -----
module msfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_payload_byte,
  input logic       out_first_byte,
  input logic       out_last_byte
);

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // backpressure reaches the input only when a word is already waiting
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no word on the output");

  // no word without an accepted byte behind it
  a_word_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("out_valid rose without an accepted byte");

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_first_byte) && $stable(out_last_byte))
    else $error("stalled output word changed");

endmodule

bind magic_sync_frame_deframer msfd_checker u_msfd_checker (.*);

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msfd_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_data_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_payload_byte;
  logic              out_first_byte;
  logic              out_last_byte;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  magic_sync_frame_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_first_byte   (out_first_byte),
    .out_last_byte    (out_last_byte),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // deframer state as the testbench sees it
  logic [47:0]      hunt_window = '0;
  logic [2:0]       hunt_fill = '0;
  phase_t           rx_phase = PH_HUNT;
  logic [3:0]       hdr_idx = '0;
  logic [15:0]      frm_type = '0;
  logic [31:0]      frm_len = '0;
  logic [LEN_W-1:0] bytes_due = '0;
  logic [LEN_W-1:0] len_limit = MAX_PAYLOAD_RESET;
  logic [15:0]      pass_type = TYPE_RESET;

  result_t    payload_q[$];
  logic [7:0] stream_q[$];

  int in_idle_pct = 28;
  int out_idle_pct = 28;
  int n_queued = 0;
  int n_bytes = 0;
  int n_words = 0;
  int n_frames = 0;
  int n_writes = 0;
  int n_mismatch = 0;

  logic [31:0] limit_set [7] = '{32'd0, 32'hFFFF_FFFF, 32'd16777216, 32'd5,
                                 32'h0300_0005, 32'd64, 32'd1048576};
  logic [31:0] type_set [7]  = '{32'h0000_FFFF, 32'd0, 32'd0, 32'd1,
                                 32'h0000_8000, 32'd7, 32'd1};

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic void rehunt();
    hunt_window = '0;
    hunt_fill   = '0;
    hdr_idx     = '0;
    rx_phase    = PH_HUNT;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    result_t w;
    case (rx_phase)
      PH_HEAD: begin
        if (hdr_idx == HDR_START || hdr_idx == HDR_TYPE_LAST)
          frm_type = {frm_type[7:0], b};
        else if (hdr_idx >= HDR_LEN_FIRST && hdr_idx <= HDR_LEN_LAST)
          frm_len = {frm_len[23:0], b};
        if (hdr_idx != HDR_LAST) begin
          hdr_idx++;
        end else if (frm_len == 0 || frm_len > 32'(len_limit)) begin
          rehunt();
        end else begin
          bytes_due = frm_len[LEN_W-1:0];
          rx_phase  = PH_BODY;
        end
      end
      PH_BODY: begin
        // type is compared per byte, so a register write mid-frame bites at once
        if (frm_type == pass_type) begin
          w.payload_byte = b;
          w.first_byte   = (bytes_due == frm_len[LEN_W-1:0]);
          w.last_byte    = (bytes_due == 1);
          payload_q.push_back(w);
        end
        if (bytes_due <= 1) begin
          bytes_due = '0;
          rehunt();
        end else begin
          bytes_due--;
        end
      end
      default: begin
        rx_phase    = PH_HUNT;
        hunt_window = {hunt_window[39:0], b};
        if (hunt_fill < SYNC_FILL) hunt_fill++;
        if (hunt_fill == SYNC_FILL && hunt_window == SYNC_PATTERN) begin
          rx_phase = PH_HEAD;
          hdr_idx  = HDR_START;
          frm_type = '0;
          frm_len  = '0;
        end
      end
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    stream_q.push_back(b);
    n_queued++;
  endfunction

  function automatic void add_header(input logic [15:0] ftype, input logic [31:0] flen,
                                     input logic [15:0] ver);
    for (int i = 0; i < 4; i++) add_byte(SYNC_MAGIC[31-8*i -: 8]);
    add_byte(ver[15:8]);
    add_byte(ver[7:0]);
    add_byte(ftype[15:8]);
    add_byte(ftype[7:0]);
    for (int i = 0; i < 4; i++) add_byte(flen[31-8*i -: 8]);
    for (int i = 0; i < 4; i++) add_byte(8'($urandom));
  endfunction

  function automatic void add_frame(input logic [15:0] ftype, input logic [31:0] flen);
    add_header(ftype, flen, SYNC_VERSION);
    if (flen != 0 && flen <= 32'(len_limit)) begin
      n_frames++;
      for (int i = 0; i < flen; i++) add_byte(8'($urandom));
    end
  endfunction

  // mostly well-formed frames, the rest line noise and cut or corrupted headers
  task automatic add_traffic(input int n);
    int          k;
    int          j;
    int          stop;
    logic [15:0] ftype;
    logic [31:0] flen;
    stop = n_queued + n;
    while (n_queued < stop) begin
      k = $urandom_range(0, 99);
      if (k < 70) begin
        ftype = ($urandom_range(0, 99) < 65) ? pass_type : 16'($urandom);
        k = $urandom_range(0, 99);
        if (k < 8)
          flen = '0;
        else if (k < 14)
          flen = '1;
        else if (k < 22)
          flen = 32'(len_limit) + 32'($urandom_range(1, 300));
        else if (k < 34 && len_limit <= 64)
          flen = 32'(len_limit) - 32'($urandom_range(0, 1));
        else
          flen = $urandom_range(1, 24);
        add_frame(ftype, flen);
      end else if (k < 85) begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      end else begin
        j = $urandom_range(1, 5);
        for (int i = 0; i < j; i++) add_byte(SYNC_PATTERN[47-8*i -: 8]);
        add_byte(8'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (stream_q.size() != 0 || in_valid || payload_q.size() != 0);
    // let a word still in flight show up
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_MAX_PAYLOAD) len_limit = value[LEN_W-1:0];
    else pass_type = value[15:0];
    n_writes++;
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_data_byte);
        n_bytes++;
      end
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          in_valid     <= 1'b1;
          in_data_byte <= stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // payload monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_words++;
        if (payload_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h first %b last %b",
                                    out_payload_byte, out_first_byte, out_last_byte));
        end else begin
          want = payload_q.pop_front();
          if (out_payload_byte !== want.payload_byte || out_first_byte !== want.first_byte ||
              out_last_byte !== want.last_byte)
            report_mismatch($sformatf("word %0d: got %h/%b/%b, expected %h/%b/%b", n_words,
                                      out_payload_byte, out_first_byte, out_last_byte,
                                      want.payload_byte, want.first_byte, want.last_byte));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty frame behind a doubled first magic byte, then a one-byte frame
    add_byte(SYNC_MAGIC[31:24]);
    add_header(TYPE_RESET, 32'd0, SYNC_VERSION);
    add_header(TYPE_RESET, 32'd1, SYNC_VERSION);
    add_byte(8'hFF);
    wait_idle();

    for (int s = 0; s < 7; s++) begin
      write_reg(REG_MAX_PAYLOAD, limit_set[s]);
      write_reg(REG_ACCEPTED_TYPE, (s == 2) ? 32'($urandom_range(2, 16'hFFFE)) : type_set[s]);
      in_idle_pct  = (s == 5) ? 0 : 28;
      out_idle_pct = (s == 5) ? 0 : 28;
      add_traffic(200);
      wait_idle();
    end

    // switch the accepted type while a frame's payload is under way
    add_header(pass_type, 32'd40, SYNC_VERSION);
    repeat (10) add_byte(8'($urandom));
    wait_idle();
    write_reg(REG_ACCEPTED_TYPE, 32'h0000_5A5A);
    repeat (15) add_byte(8'($urandom));
    wait_idle();
    write_reg(REG_ACCEPTED_TYPE, 32'(TYPE_RESET));
    repeat (15) add_byte(8'($urandom));
    add_traffic(60);
    wait_idle();

    $display("streamed %0d bytes, checked %0d payload words over %0d passed frames",
             n_bytes, n_words, n_frames);
    $display("%0d register writes: limits from zero to the 25-bit top, type swapped mid-frame",
             n_writes);
    if (n_mismatch == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: deframer did not drain");
    $display("simulation failed");
    $finish;
  end

endmodule
